// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle, sampled on clk_i, off during reset.
`define UPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define UPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/upq_pkg.sv -----
// Types, codes and constants of the unsorted priority queue.
package upq_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned DepthDef = 16;

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_UPD = 2'd1,
    ACT_DEQ = 2'd2,
    ACT_NOP = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // One request as it arrives
  typedef struct packed {
    act_e                     action;
    logic signed [DataW-1:0]  data_value;
    logic signed [DataW-1:0]  priority_req;
    logic signed [DataW-1:0]  match_data;
    logic signed [DataW-1:0]  match_priority;
  } req_t;

  // One result
  typedef struct packed {
    stat_e                    status;
    logic [CountW-1:0]        entry_count;
    logic                     queue_empty;
    logic signed [DataW-1:0]  top_priority;
  } res_t;

  // One table entry held by a cell
  typedef struct packed {
    logic signed [DataW-1:0]  data;
    logic signed [DataW-1:0]  prio;
  } entry_t;

  // Indexed write broadcast to the cells
  typedef struct packed {
    logic en;
    logic prio_en;
  } wr_ctl_t;

endpackage

// ----- sv/upq_cell.sv -----
// One cell of the entry ring: holds one entry, shifts or takes an indexed write.
module upq_cell import upq_pkg::*; #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            shift_i,
  input  entry_t          nbr_i,
  input  wr_ctl_t         wr_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  entry_t          wr_entry_i,
  output entry_t          ent_o
);

  entry_t ent_q;
  logic   sel;

  assign sel = wr_i.en && (wr_idx_i == IdxW'(CellIdx));

  // Rotate with the ring, or take the write addressed to this slot
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= nbr_i;
    end else if (sel) begin
      ent_q.data <= wr_entry_i.data;
      if (wr_i.prio_en) begin
        ent_q.prio <= wr_entry_i.prio;
      end
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- sv/upq_ctrl.sv -----
// Sequencer: watches the ring head during one rotation, then writes back and reports.
module upq_ctrl import upq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  req_t                         req_i,
  output logic                         busy_o,
  input  entry_t                       head_i,
  output logic                         shift_o,
  output wr_ctl_t                      wr_o,
  output logic [$clog2(DEPTH)-1:0]     wr_idx_o,
  output entry_t                       wr_entry_o,
  output logic                         res_valid_o,
  output res_t                         res_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e                  state_q, state_d;
  req_t                    req_q, req_d;
  logic [IdxW-1:0]         step_q, step_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    found_q, found_d;
  logic [IdxW-1:0]         hit_q, hit_d;
  entry_t                  last_q, last_d;
  logic signed [DataW-1:0] best_q, best_d;
  logic                    bvld_q, bvld_d;
  logic                    rvld_q, rvld_d;
  res_t                    res_q, res_d;

  logic                    in_range, is_match, first_hit, fold;
  logic signed [DataW-1:0] top_fin;
  logic                    tvld_fin;

  // Scan decisions on the entry now at the ring head
  always_comb begin
    in_range = CntW'(step_q) < count_q;
    is_match = ((req_q.action == ACT_UPD) && (head_i.data == req_q.match_data)) ||
               ((req_q.action == ACT_DEQ) && (head_i.prio == req_q.match_priority));
    first_hit = in_range && is_match && !found_q;
    fold = in_range && !((req_q.action == ACT_DEQ) && first_hit);
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    step_d   = step_q;
    count_d  = count_q;
    found_d  = found_q;
    hit_d    = hit_q;
    last_d   = last_q;
    best_d   = best_q;
    bvld_d   = bvld_q;
    rvld_d   = 1'b0;
    res_d    = res_q;
    shift_o  = 1'b0;
    wr_o     = '0;
    wr_idx_o = hit_q;
    wr_entry_o.data = req_q.data_value;
    wr_entry_o.prio = req_q.priority_req;
    top_fin  = best_q;
    tvld_fin = bvld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          step_d  = '0;
          found_d = 1'b0;
          bvld_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift_o = 1'b1;
        step_d  = step_q + 1'b1;
        if (first_hit) begin
          found_d = 1'b1;
          hit_d   = step_q;
        end
        if (CntW'(step_q) + CntW'(1) == count_q) begin
          last_d = head_i;
        end
        // Running maximum of the priorities that stay in the table
        if (fold && (!bvld_q || (head_i.prio > best_q))) begin
          best_d = head_i.prio;
          bvld_d = 1'b1;
        end
        if (step_q == IdxW'(DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_d.status = STAT_OK;
        unique case (req_q.action)
          ACT_ENQ: begin
            if (count_q == CntW'(DEPTH)) begin
              res_d.status = STAT_FULL;
            end else begin
              wr_o.en    = 1'b1;
              wr_o.prio_en = 1'b1;
              wr_idx_o   = count_q[IdxW-1:0];
              count_d    = count_q + 1'b1;
              if (!bvld_q || (req_q.priority_req > best_q)) begin
                top_fin  = req_q.priority_req;
                tvld_fin = 1'b1;
              end
            end
          end
          ACT_UPD, ACT_DEQ: begin
            if (count_q == '0) begin
              res_d.status = STAT_EMPTY;
            end else if (!found_q) begin
              res_d.status = STAT_NOTFOUND;
            end else if (req_q.action == ACT_UPD) begin
              wr_o.en = 1'b1;
            end else begin
              // Last entry fills the hole left by the dequeued one
              wr_o.en      = 1'b1;
              wr_o.prio_en = 1'b1;
              wr_entry_o   = last_q;
              count_d      = count_q - 1'b1;
            end
          end
          default: ;
        endcase
        res_d.entry_count  = CountW'(count_d);
        res_d.queue_empty  = (count_d == '0);
        res_d.top_priority = (tvld_fin && (count_d != '0)) ? top_fin : '1;
        rvld_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rvld_q  <= rvld_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    step_q  <= step_d;
    found_q <= found_d;
    hit_q   <= hit_d;
    last_q  <= last_d;
    best_q  <= best_d;
    bvld_q  <= bvld_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = rvld_q;
  assign res_o       = res_q;

endmodule

// ----- sv/unsorted_priority_queue.sv -----
// Top level of the unsorted priority queue: ring of entry cells plus sequencer.
//
// A request is accepted at a rising edge with start_i high and busy_o low. It then
// passes through these sequencer states in order:
// - ST_SCAN, in which the entry ring makes one full rotation past the head
//   cell. There the sequencer compares, and tracks the first match, the last entry
//   and the running maximum priority.
// - ST_DONE, to write back and register the result.
// After ST_DONE the result is shown, with the result strobe res_valid_o high.
// busy_o is high from the accepting edge until the result is shown. A new request
// may be issued in the cycle that res_valid_o is high, so the block takes no new
// request until the result of the last one is shown. The result is valid for
// exactly that one cycle and cannot be held off. top_priority reads all ones when
// the queue is empty.
module unsorted_priority_queue import upq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  entry_t          ring [DEPTH];
  logic            shift;
  wr_ctl_t         wr;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_entry;

  // Sequencer
  upq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .head_i     (ring[0]),
    .shift_o    (shift),
    .wr_o       (wr),
    .wr_idx_o   (wr_idx),
    .wr_entry_o (wr_entry),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Ring of cells; each takes its right neighbor, the last wraps to the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    upq_cell #(
      .IdxW   (IdxW),
      .CellIdx(i)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .nbr_i     (ring[(i + 1) % DEPTH]),
      .wr_i      (wr),
      .wr_idx_i  (wr_idx),
      .wr_entry_i(wr_entry),
      .ent_o     (ring[i])
    );
  end

endmodule

// ----- sv/upq_checker.sv -----
// Port-level checker for the unsorted priority queue, bound to the top level.
`include "assert_macros.svh"

module upq_checker import upq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic res_valid_o,
  input res_t res_o
);

  // An accepted request keeps the block busy in the next cycle
  `UPQ_ASSERT_NEXT(a_busy_after_accept, start_i && !busy_o, busy_o, "not busy after accept")
  // The result is shown when the block is ready again
  `UPQ_ASSERT(a_idle_on_result, !res_valid_o || !busy_o, "result while busy")
  // Empty flag agrees with the count
  `UPQ_ASSERT(a_empty_flag, !res_valid_o || (res_o.queue_empty == (res_o.entry_count == '0)), "empty flag mismatch")
  // Empty queue reports all ones as top priority
  `UPQ_ASSERT(a_empty_top, !res_valid_o || !res_o.queue_empty || (res_o.top_priority == '1), "top of empty queue")
  // Count never exceeds the depth
  `UPQ_ASSERT(a_count_bound, !res_valid_o || (32'(res_o.entry_count) <= DEPTH), "count above depth")

endmodule

bind unsorted_priority_queue upq_checker #(
  .DEPTH(DEPTH)
) u_upq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

// ----- dv/tb_unsorted_priority_queue.sv -----
// Testbench for the unsorted priority queue: directed and random requests, table predictor.
module tb_unsorted_priority_queue;
  import upq_pkg::*;

  localparam int unsigned NumRandom  = 800;
  localparam int unsigned CycleLimit = 200000;

  // One queued request with its sender gap and an optional drain before it
  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start_i     = 1'b0;
  req_t req_i       = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  // Predicted table contents
  logic signed [DataW-1:0] tbl_data [DepthDef];
  logic signed [DataW-1:0] tbl_prio [DepthDef];
  int unsigned             tbl_fill = 0;

  stim_t       todo_reqs [$];
  res_t        pending_results [$];
  stim_t       next_item;
  bit          have_next = 1'b0;
  int unsigned idle_left = 0;
  bit          took = 1'b0;
  res_t        exp_res;

  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_cycles   = 0;
  int unsigned stat_seen [4] = '{0, 0, 0, 0};

  unsorted_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one request to the predicted table and return the result it should give
  function automatic res_t apply_to_table(req_t r);
    res_t                    res;
    stat_e                   st;
    int                      hit;
    int unsigned             i;
    logic signed [DataW-1:0] best;
    st  = STAT_OK;
    hit = -1;
    case (r.action)
      ACT_ENQ: begin
        if (tbl_fill >= DepthDef) begin
          st = STAT_FULL;
        end else begin
          tbl_data[tbl_fill] = r.data_value;
          tbl_prio[tbl_fill] = r.priority_req;
          tbl_fill++;
        end
      end
      ACT_UPD, ACT_DEQ: begin
        if (tbl_fill == 0) begin
          st = STAT_EMPTY;
        end else begin
          // first match in index order
          for (i = 0; i < tbl_fill && hit < 0; i++) begin
            if (r.action == ACT_UPD ? tbl_data[i] == r.match_data
                                    : tbl_prio[i] == r.match_priority) hit = i;
          end
          if (hit < 0) begin
            st = STAT_NOTFOUND;
          end else if (r.action == ACT_UPD) begin
            tbl_data[hit] = r.data_value;
          end else begin
            // last entry fills the hole
            tbl_data[hit] = tbl_data[tbl_fill-1];
            tbl_prio[hit] = tbl_prio[tbl_fill-1];
            tbl_fill--;
          end
        end
      end
      default: ;
    endcase
    // highest priority held, all ones when empty
    best = '1;
    if (tbl_fill != 0) begin
      best = tbl_prio[0];
      for (i = 1; i < tbl_fill; i++) begin
        if (tbl_prio[i] > best) best = tbl_prio[i];
      end
    end
    res.status       = st;
    res.entry_count  = CountW'(tbl_fill);
    res.queue_empty  = (tbl_fill == 0);
    res.top_priority = best;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h, expected %0h", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic queue_req(act_e act, logic signed [DataW-1:0] dval,
                           logic signed [DataW-1:0] pval, logic signed [DataW-1:0] mdat,
                           logic signed [DataW-1:0] mpri, int unsigned gap, bit drain);
    stim_t s;
    s.req.action         = act;
    s.req.data_value     = dval;
    s.req.priority_req   = pval;
    s.req.match_data     = mdat;
    s.req.match_priority = mpri;
    s.gap                = gap;
    s.drain              = drain;
    todo_reqs.push_back(s);
  endtask

  // Mostly a small pool so that searches hit, sometimes any value
  function automatic logic signed [DataW-1:0] pick_val();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'shFFFF;
      3:       return 16'sh0000;
      4:       return 16'sh0007;
      5:       return 16'shFED4;
      default: return DataW'($urandom);
    endcase
  endfunction

  // Driver: presents the next request at the falling edge once its gap has passed
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !took)) begin
      if (!have_next && todo_reqs.size() != 0) begin
        next_item = todo_reqs.pop_front();
        idle_left = next_item.gap;
        have_next = 1'b1;
      end
      if (have_next && idle_left == 0 && !(next_item.drain && pending_results.size() != 0)) begin
        req_i     <= next_item.req;
        start_i   <= 1'b1;
        have_next = 1'b0;
      end else begin
        start_i <= 1'b0;
        // gap counts only cycles in which the block could take a request
        if (have_next && idle_left != 0 && !busy_o) idle_left--;
      end
    end
  end

  // Monitor: check results against the oldest prediction, then record a new request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        n_results++;
        if (pending_results.size() == 0) begin
          flag_mismatch("arrived with none pending", 32'(res_o), 32'd0);
        end else begin
          exp_res = pending_results.pop_front();
          stat_seen[exp_res.status]++;
          if (res_o.status !== exp_res.status)
            flag_mismatch("status", 32'(res_o.status), 32'(exp_res.status));
          if (res_o.entry_count !== exp_res.entry_count)
            flag_mismatch("entry_count", 32'(res_o.entry_count), 32'(exp_res.entry_count));
          if (res_o.queue_empty !== exp_res.queue_empty)
            flag_mismatch("queue_empty", 32'(res_o.queue_empty), 32'(exp_res.queue_empty));
          if (res_o.top_priority !== exp_res.top_priority)
            flag_mismatch("top_priority", 32'(res_o.top_priority), 32'(exp_res.top_priority));
        end
      end
      took = start_i && !busy_o;
      if (took) begin
        pending_results.push_back(apply_to_table(req_i));
        n_accepted++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned             k;
    int unsigned             seg_left;
    int unsigned             w;
    bit                      fill_phase;
    bit                      rush;
    act_e                    act;
    logic signed [DataW-1:0] dval;
    logic signed [DataW-1:0] pval;

    // Directed: operations on an empty table
    queue_req(ACT_UPD, 16'sh1234, 16'sh0000, 16'sh1234, 16'sh0000, 0, 1'b0);
    queue_req(ACT_DEQ, 16'sh0000, 16'sh0000, 16'sh0000, 16'shFFFF, 3, 1'b0);
    queue_req(ACT_NOP, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 0, 1'b0);
    // Fill to capacity with extremes, tied top priorities and repeated data
    for (k = 0; k < DepthDef; k++) begin
      dval = DataW'(k * 16'h1111 + 3);
      if (k == 0) dval = 16'sh7FFF;
      if (k == 1) dval = 16'sh8000;
      if (k == 4 || k == 11) dval = 16'sh0055;
      pval = DataW'(k * 977) - 16'sd3000;
      if (k == 2 || k == 9) pval = 16'sh7FFF;
      if (k == 3) pval = 16'sh8000;
      if (k == DepthDef - 1) pval = 16'shFFFF;
      queue_req(ACT_ENQ, dval, pval, ~dval, ~pval, k % 3, 1'b0);
    end
    // Full table, then searches that hit the first of duplicates and that miss
    queue_req(ACT_ENQ, 16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004, 0, 1'b1);
    queue_req(ACT_NOP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 0, 1'b0);
    queue_req(ACT_UPD, 16'sh0066, 16'sh0000, 16'sh0055, 16'sh0000, 1, 1'b0);
    queue_req(ACT_UPD, 16'sh8000, 16'sh0000, 16'sh0055, 16'sh0000, 0, 1'b0);
    queue_req(ACT_UPD, 16'sh0000, 16'sh0000, 16'sh4444, 16'sh0000, 0, 1'b0);
    queue_req(ACT_DEQ, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 2, 1'b0);
    queue_req(ACT_DEQ, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 0, 1'b0);
    queue_req(ACT_DEQ, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh1235, 0, 1'b0);

    // Random: alternating fill-heavy and drain-heavy stretches
    seg_left   = 0;
    fill_phase = 1'b0;
    rush       = 1'b0;
    for (k = 0; k < NumRandom; k++) begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(20, 60);
        fill_phase = !fill_phase;
        rush       = ($urandom_range(0, 2) == 0);
      end
      seg_left--;
      w = $urandom_range(0, 99);
      if (fill_phase) begin
        act = (w < 60) ? ACT_ENQ : (w < 75) ? ACT_UPD : (w < 95) ? ACT_DEQ : ACT_NOP;
      end else begin
        act = (w < 20) ? ACT_ENQ : (w < 45) ? ACT_UPD : (w < 95) ? ACT_DEQ : ACT_NOP;
      end
      queue_req(act, pick_val(), pick_val(), pick_val(), pick_val(),
                rush ? 0 : $urandom_range(0, 11), ($urandom_range(0, 59) == 0));
    end

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all requests to go out and all results to come back
    while (todo_reqs.size() != 0 || have_next || start_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DepthDef + 10) @(posedge clk_i);

    $display("Ran %0d requests, checked %0d results: ok %0d, full %0d, empty %0d, not found %0d",
             n_accepted, n_results, stat_seen[STAT_OK], stat_seen[STAT_FULL],
             stat_seen[STAT_EMPTY], stat_seen[STAT_NOTFOUND]);
    $display("Mismatches counted: %0d", n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
